>>> rtl/pdl_pkg.sv
// Package of the keypad door lock: sizes, key codes, modes, message and register codes.
package pdl_pkg;

  // Longest password that is stored, and the widths that follow from it
  localparam int PASS_MAX = 16;
  localparam int LEN_W    = $clog2(PASS_MAX + 2);
  localparam int IDX_W    = $clog2(PASS_MAX);

  localparam int KEY_W    = 8;
  localparam int SEC_W    = 6;
  localparam int WRONG_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 6;

  // Keys with a meaning of their own
  localparam logic [KEY_W-1:0] KEY_END    = 8'd13;
  localparam logic [KEY_W-1:0] KEY_OPEN   = 8'h2B;
  localparam logic [KEY_W-1:0] KEY_CHANGE = 8'h2D;

  // Register reset values
  localparam logic [SEC_W-1:0]   TPS_RST    = 6'd31;
  localparam logic [SEC_W-1:0]   UNLOCK_RST = 6'd15;
  localparam logic [SEC_W-1:0]   HOLD_RST   = 6'd3;
  localparam logic [SEC_W-1:0]   ALARM_RST  = 6'd60;
  localparam logic [WRONG_W-1:0] MAXW_RST   = 2'd3;

  typedef enum logic [0:0] {
    REQ_KEY  = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    M_FIRST   = 3'd0,
    M_CONFIRM = 3'd1,
    M_MENU    = 3'd2,
    M_ATTEMPT = 3'd3,
    M_FWD     = 3'd4,
    M_HOLD    = 3'd5,
    M_REV     = 3'd6,
    M_ALARM   = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    MSG_AGAIN    = 3'd0,
    MSG_MENU     = 3'd1,
    MSG_WRONG    = 3'd2,
    MSG_ENTER    = 3'd3,
    MSG_UNLOCKED = 3'd4,
    MSG_INTRUDER = 3'd5,
    MSG_MATCH    = 3'd6
  } msg_e;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_FWD  = 2'd1,
    MOTOR_REV  = 2'd2
  } motor_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPS    = 3'd0,
    CFG_UNLOCK = 3'd1,
    CFG_HOLD   = 3'd2,
    CFG_ALARM  = 3'd3,
    CFG_MAXW   = 3'd4
  } cfg_idx_e;

endpackage

>>> rtl/pdl_in_if.sv
// Input channel of the keypad door lock: one key byte or timer tick per word.
interface pdl_in_if import pdl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [KEY_W-1:0] key_byte;

  modport source (output valid, req_type, key_byte, input ready);
  modport sink   (input valid, req_type, key_byte, output ready);
endinterface

>>> rtl/pdl_out_if.sv
// Result channel of the keypad door lock: message, motor drive and buzzer per word.
interface pdl_out_if import pdl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       msg_valid;
  logic [2:0] msg_code;
  logic [1:0] motor_drive;
  logic       siren_on;

  modport source (output valid, msg_valid, msg_code, motor_drive, siren_on, input ready);
  modport sink   (input valid, msg_valid, msg_code, motor_drive, siren_on, output ready);
endinterface

>>> rtl/pdl_cfg_if.sv
// Configuration write channel of the keypad door lock: register index and data per word.
interface pdl_cfg_if import pdl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/password_door_lock_controller_top.sv
// Keypad door lock controller: password store, menu, motor and alarm sequencing.
//
// Each accepted input word (a key byte or a timer tick) updates the lock state
// in the cycle it is accepted and produces one result word in the output
// register on the next cycle, so one word is taken per clock unless the
// receiver stalls. Input is accepted whenever the output register is empty or
// its word is taken in the same cycle. The password is held in a small register
// file of PASS_MAX bytes, read at the current entry position. Configuration
// writes are always ready and take effect on the next word.
module password_door_lock_controller_top import pdl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdl_in_if.sink      in_i,
  pdl_out_if.source   out_o,
  pdl_cfg_if.sink     cfg_i
);

  localparam logic [LEN_W-1:0] PASS_MAX_L = LEN_W'(PASS_MAX);

  // Configuration registers
  logic [SEC_W-1:0]   tps_q, unlock_q, hold_q, alarm_q;
  logic [WRONG_W-1:0] maxw_q;

  // Lock state
  mode_e              mode_q, mode_d;
  logic [KEY_W-1:0]   stored_q [PASS_MAX];
  logic [LEN_W-1:0]   stored_len_q, stored_len_d;
  logic [LEN_W-1:0]   att_len_q, att_len_d;
  logic               att_diff_q, att_diff_d;
  logic [WRONG_W-1:0] wrong_q, wrong_d;
  logic [SEC_W-1:0]   tick_q, tick_d;
  logic [SEC_W-1:0]   sec_q, sec_d;
  logic               open_q, open_d;
  logic               store_we;

  // Result register
  logic               out_valid_q;
  logic               msg_valid_q, msg_valid_d;
  msg_e               msg_code_q, msg_code_d;
  motor_e             motor_q, motor_d;
  logic               buzzer_q, buzzer_d;

  logic               in_acc;
  logic               is_tick;
  logic [KEY_W-1:0]   key;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign is_tick     = (in_i.req_type == REQ_TICK);
  assign key         = in_i.key_byte;
  assign cfg_i.ready = 1'b1;

  // Entry compare helpers
  logic               att_in_range;
  logic               att_key_diff;
  logic               att_match;
  logic [LEN_W-1:0]   att_len_inc;
  logic [LEN_W-1:0]   stored_len_inc;

  assign att_in_range = (att_len_q < stored_len_q) && (att_len_q < PASS_MAX_L);
  assign att_key_diff = !att_in_range || (stored_q[att_len_q[IDX_W-1:0]] != key);
  assign att_len_inc  = (att_len_q <= PASS_MAX_L) ? att_len_q + LEN_W'(1) : att_len_q;
  assign stored_len_inc = (stored_len_q <= PASS_MAX_L) ? stored_len_q + LEN_W'(1)
                                                       : stored_len_q;
  assign att_match    = !att_diff_q && (att_len_q == stored_len_q) &&
                        (stored_len_q != '0) && (stored_len_q <= PASS_MAX_L);

  // Timer helpers
  logic [SEC_W-1:0]   tps_eff;
  logic [SEC_W-1:0]   tick_inc;
  logic               sec_roll;
  logic [SEC_W-1:0]   sec_new;
  logic [SEC_W-1:0]   span;
  logic [WRONG_W-1:0] wrong_inc;
  logic [WRONG_W-1:0] wrong_lim;

  assign tps_eff   = (tps_q == '0) ? SEC_W'(1) : tps_q;
  assign tick_inc  = tick_q + SEC_W'(1);
  assign sec_roll  = (tick_inc >= tps_eff);
  assign sec_new   = sec_roll ? sec_q + SEC_W'(1) : sec_q;
  assign span      = (mode_q == M_HOLD)  ? hold_q  :
                     (mode_q == M_ALARM) ? alarm_q : unlock_q;
  assign wrong_inc = wrong_q + WRONG_W'(1);
  assign wrong_lim = (maxw_q == '0) ? WRONG_W'(1) : maxw_q;

  // Next state and message for the word at the input
  always_comb begin
    mode_d       = mode_q;
    stored_len_d = stored_len_q;
    att_len_d    = att_len_q;
    att_diff_d   = att_diff_q;
    wrong_d      = wrong_q;
    tick_d       = tick_q;
    sec_d        = sec_q;
    open_d       = open_q;
    store_we     = 1'b0;
    msg_valid_d  = 1'b0;
    msg_code_d   = MSG_AGAIN;

    if (is_tick) begin
      if (mode_q inside {M_FWD, M_HOLD, M_REV, M_ALARM}) begin
        tick_d = sec_roll ? '0 : tick_inc;
        sec_d  = sec_new;
        if (sec_new >= span) begin
          tick_d = '0;
          sec_d  = '0;
          case (mode_q)
            M_FWD:   mode_d = (hold_q != '0) ? M_HOLD : M_REV;
            M_HOLD:  mode_d = M_REV;
            M_ALARM: begin
              wrong_d     = '0;
              mode_d      = M_MENU;
              msg_valid_d = 1'b1;
              msg_code_d  = MSG_MENU;
            end
            default: begin
              mode_d      = M_MENU;
              msg_valid_d = 1'b1;
              msg_code_d  = MSG_MENU;
            end
          endcase
        end
      end
    end else begin
      case (mode_q)
        M_FIRST: begin
          if (key == KEY_END) begin
            mode_d      = M_CONFIRM;
            att_len_d   = '0;
            att_diff_d  = 1'b0;
            msg_valid_d = 1'b1;
            msg_code_d  = MSG_AGAIN;
          end else begin
            store_we     = (stored_len_q < PASS_MAX_L);
            stored_len_d = stored_len_inc;
          end
        end
        M_CONFIRM: begin
          if (key == KEY_END) begin
            msg_valid_d = 1'b1;
            if (att_match) begin
              mode_d     = M_MENU;
              msg_code_d = MSG_MENU;
            end else begin
              mode_d       = M_FIRST;
              stored_len_d = '0;
              msg_code_d   = MSG_WRONG;
            end
          end else begin
            att_diff_d = att_diff_q || att_key_diff;
            att_len_d  = att_len_inc;
          end
        end
        M_MENU: begin
          msg_valid_d = 1'b1;
          msg_code_d  = MSG_ENTER;
          if (key == KEY_OPEN || key == KEY_CHANGE) begin
            open_d     = (key == KEY_OPEN);
            mode_d     = M_ATTEMPT;
            att_len_d  = '0;
            att_diff_d = 1'b0;
          end
        end
        M_ATTEMPT: begin
          if (key == KEY_END) begin
            msg_valid_d = 1'b1;
            if (att_match) begin
              wrong_d = '0;
              if (open_q) begin
                mode_d     = M_FWD;
                tick_d     = '0;
                sec_d      = '0;
                msg_code_d = MSG_UNLOCKED;
              end else begin
                mode_d       = M_FIRST;
                stored_len_d = '0;
                msg_code_d   = MSG_MATCH;
              end
            end else begin
              wrong_d = wrong_inc;
              if (wrong_inc >= wrong_lim || wrong_inc == '0) begin
                mode_d     = M_ALARM;
                tick_d     = '0;
                sec_d      = '0;
                msg_code_d = MSG_INTRUDER;
              end else begin
                att_len_d  = '0;
                att_diff_d = 1'b0;
                msg_code_d = MSG_WRONG;
              end
            end
          end else begin
            att_diff_d = att_diff_q || att_key_diff;
            att_len_d  = att_len_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Drive motor and buzzer from the mode after the word
  always_comb begin
    motor_d  = MOTOR_STOP;
    buzzer_d = 1'b0;
    case (mode_d)
      M_FWD:   motor_d  = MOTOR_FWD;
      M_REV:   motor_d  = MOTOR_REV;
      M_ALARM: buzzer_d = 1'b1;
      default: ;
    endcase
  end

  // Take configuration writes; drop indexes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q    <= TPS_RST;
      unlock_q <= UNLOCK_RST;
      hold_q   <= HOLD_RST;
      alarm_q  <= ALARM_RST;
      maxw_q   <= MAXW_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_TPS:    tps_q    <= cfg_i.data;
        CFG_UNLOCK: unlock_q <= cfg_i.data;
        CFG_HOLD:   hold_q   <= cfg_i.data;
        CFG_ALARM:  alarm_q  <= cfg_i.data;
        CFG_MAXW:   maxw_q   <= cfg_i.data[WRONG_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance lock state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_FIRST;
      stored_len_q <= '0;
      att_len_q    <= '0;
      att_diff_q   <= 1'b0;
      wrong_q      <= '0;
      tick_q       <= '0;
      sec_q        <= '0;
      open_q       <= 1'b0;
    end else if (in_acc) begin
      mode_q       <= mode_d;
      stored_len_q <= stored_len_d;
      att_len_q    <= att_len_d;
      att_diff_q   <= att_diff_d;
      wrong_q      <= wrong_d;
      tick_q       <= tick_d;
      sec_q        <= sec_d;
      open_q       <= open_d;
    end
  end

  // Store password keys of the first entry
  always_ff @(posedge clk_i) begin
    if (in_acc && store_we) begin
      stored_q[stored_len_q[IDX_W-1:0]] <= key;
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      msg_valid_q <= msg_valid_d;
      msg_code_q  <= msg_code_d;
      motor_q     <= motor_d;
      buzzer_q    <= buzzer_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.msg_valid   = msg_valid_q;
  assign out_o.msg_code    = msg_code_q;
  assign out_o.motor_drive = motor_q;
  assign out_o.siren_on    = buzzer_q;

endmodule

>>> rtl/pdl_checker.sv
// Port checker of the keypad door lock, bound to the top level.
module pdl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       msg_valid_i,
  input logic [2:0] msg_code_i,
  input logic [1:0] motor_drive_i,
  input logic       siren_on_i
);

  // Stalled result word holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({msg_valid_i, msg_code_i, motor_drive_i, siren_on_i}))
    else $error("result word changed while stalled");

  // Empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output register");

  // Every accepted word yields a result word next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted word gave no result");

  // No message means code zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !msg_valid_i |-> msg_code_i == 3'd0)
    else $error("message code set without message");

  // Buzzer only sounds with the motor stopped, and the motor code stays legal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> motor_drive_i != 2'd3 && (!siren_on_i || motor_drive_i == 2'd0))
    else $error("illegal motor and buzzer combination");

endmodule

bind password_door_lock_controller_top pdl_checker u_pdl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .msg_valid_i   (out_o.msg_valid),
  .msg_code_i    (out_o.msg_code),
  .motor_drive_i (out_o.motor_drive),
  .siren_on_i    (out_o.siren_on)
);

>>> tb/password_door_lock_controller_checker.sv
// Checker for the keypad door lock: predicts every result word and compares it on the output channel.
`timescale 1ns / 1ps

module password_door_lock_controller_checker import pdl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pdl_in_if    in_i,
  pdl_out_if   out_i,
  pdl_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int REPORT_MAX = 200;

  typedef struct packed {
    logic   msg_valid;
    msg_e   msg_code;
    motor_e motor_drive;
    logic   siren_on;
  } lock_res_t;

  // Configuration copy
  logic [SEC_W-1:0]   tps_q;
  logic [SEC_W-1:0]   unlock_q;
  logic [SEC_W-1:0]   hold_q;
  logic [SEC_W-1:0]   alarm_q;
  logic [WRONG_W-1:0] maxw_q;

  // Lock state copy
  mode_e              mode_q;
  logic [KEY_W-1:0]   pw_mem [PASS_MAX];
  int                 pw_len;
  int                 try_len;
  bit                 try_bad;
  logic [WRONG_W-1:0] misses_q;
  int                 tick_n;
  int                 sec_n;
  bit                 open_q;

  lock_res_t lock_expect [$];
  int        mismatches = 0;

  function automatic void clear_lock();
    tps_q    = TPS_RST;
    unlock_q = UNLOCK_RST;
    hold_q   = HOLD_RST;
    alarm_q  = ALARM_RST;
    maxw_q   = MAXW_RST;
    mode_q   = M_FIRST;
    foreach (pw_mem[i]) pw_mem[i] = '0;
    pw_len   = 0;
    try_len  = 0;
    try_bad  = 1'b0;
    misses_q = '0;
    tick_n   = 0;
    sec_n    = 0;
    open_q   = 1'b0;
  endfunction

  function automatic void start_try(mode_e nxt);
    mode_q  = nxt;
    try_len = 0;
    try_bad = 1'b0;
  endfunction

  function automatic void start_span(mode_e nxt);
    mode_q = nxt;
    tick_n = 0;
    sec_n  = 0;
  endfunction

  // Compare one entered key with the stored password at the current position
  function automatic void take_try_key(logic [KEY_W-1:0] k);
    if (try_len < pw_len && try_len < PASS_MAX) begin
      if (pw_mem[try_len] != k) try_bad = 1'b1;
    end else begin
      try_bad = 1'b1;
    end
    if (try_len <= PASS_MAX) try_len++;
  endfunction

  function automatic bit try_ok();
    return !try_bad && try_len == pw_len && pw_len != 0 && pw_len <= PASS_MAX;
  endfunction

  // Advance the lock by one word and return the result word it causes
  function automatic lock_res_t step_lock(req_e req, logic [KEY_W-1:0] k);
    lock_res_t r;
    int tps_eff;
    int span;
    int lim;
    r.msg_valid   = 1'b0;
    r.msg_code    = MSG_AGAIN;
    r.motor_drive = MOTOR_STOP;
    r.siren_on    = 1'b0;
    if (req == REQ_TICK) begin
      // ticks only count inside a timed span
      if (mode_q >= M_FWD) begin
        tps_eff = (tps_q == 0) ? 1 : int'(tps_q);
        tick_n++;
        if (tick_n >= tps_eff) begin
          tick_n = 0;
          sec_n++;
        end
        span = (mode_q == M_HOLD) ? int'(hold_q) :
               (mode_q == M_ALARM) ? int'(alarm_q) : int'(unlock_q);
        if (sec_n >= span) begin
          case (mode_q)
            M_FWD:  start_span((hold_q != 0) ? M_HOLD : M_REV);
            M_HOLD: start_span(M_REV);
            default: begin
              if (mode_q == M_ALARM) misses_q = '0;
              start_span(M_MENU);
              r.msg_valid = 1'b1;
              r.msg_code  = MSG_MENU;
            end
          endcase
        end
      end
    end else begin
      case (mode_q)
        M_FIRST: begin
          if (k == KEY_END) begin
            start_try(M_CONFIRM);
            r.msg_valid = 1'b1;
            r.msg_code  = MSG_AGAIN;
          end else begin
            if (pw_len < PASS_MAX) pw_mem[pw_len] = k;
            if (pw_len <= PASS_MAX) pw_len++;
          end
        end
        M_CONFIRM: begin
          if (k == KEY_END) begin
            r.msg_valid = 1'b1;
            if (try_ok()) begin
              mode_q     = M_MENU;
              r.msg_code = MSG_MENU;
            end else begin
              mode_q     = M_FIRST;
              pw_len     = 0;
              r.msg_code = MSG_WRONG;
            end
          end else begin
            take_try_key(k);
          end
        end
        M_MENU: begin
          r.msg_valid = 1'b1;
          r.msg_code  = MSG_ENTER;
          if (k == KEY_OPEN) begin
            open_q = 1'b1;
            start_try(M_ATTEMPT);
          end else if (k == KEY_CHANGE) begin
            open_q = 1'b0;
            start_try(M_ATTEMPT);
          end
        end
        M_ATTEMPT: begin
          if (k == KEY_END) begin
            r.msg_valid = 1'b1;
            if (try_ok()) begin
              misses_q = '0;
              if (open_q) begin
                start_span(M_FWD);
                r.msg_code = MSG_UNLOCKED;
              end else begin
                mode_q     = M_FIRST;
                pw_len     = 0;
                r.msg_code = MSG_MATCH;
              end
            end else begin
              lim      = (maxw_q == 0) ? 1 : int'(maxw_q);
              misses_q = misses_q + 2'd1;
              if (misses_q >= lim || misses_q == 0) begin
                start_span(M_ALARM);
                r.msg_code = MSG_INTRUDER;
              end else begin
                start_try(M_ATTEMPT);
                r.msg_code = MSG_WRONG;
              end
            end
          end else begin
            take_try_key(k);
          end
        end
        default: ;
      endcase
    end
    r.motor_drive = (mode_q == M_FWD) ? MOTOR_FWD : (mode_q == M_REV) ? MOTOR_REV : MOTOR_STOP;
    r.siren_on    = (mode_q == M_ALARM);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (mismatches < REPORT_MAX) begin
        $error("%s: expected %0d, got %0d", name, want, got);
      end
      mismatches++;
    end
  endfunction

  // Track config writes, check result words, predict from input words
  always @(posedge clk_i or negedge rst_ni) begin
    lock_res_t want;
    if (!rst_ni) begin
      clear_lock();
      lock_expect.delete();
      fail_count_o <= mismatches;
      pending_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_TPS:    tps_q    = cfg_i.data;
          CFG_UNLOCK: unlock_q = cfg_i.data;
          CFG_HOLD:   hold_q   = cfg_i.data;
          CFG_ALARM:  alarm_q  = cfg_i.data;
          CFG_MAXW:   maxw_q   = cfg_i.data[WRONG_W-1:0];
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        if (lock_expect.size() == 0) begin
          if (mismatches < REPORT_MAX) $error("result word with no word expected");
          mismatches++;
        end else begin
          want = lock_expect.pop_front();
          check_field("msg_valid", 8'(want.msg_valid), 8'(out_i.msg_valid));
          check_field("msg_code", 8'(want.msg_code), 8'(out_i.msg_code));
          check_field("motor_drive", 8'(want.motor_drive), 8'(out_i.motor_drive));
          check_field("siren_on", 8'(want.siren_on), 8'(out_i.siren_on));
        end
      end
      if (in_i.valid && in_i.ready) begin
        lock_expect.push_back(step_lock(req_e'(in_i.req_type), in_i.key_byte));
      end
      fail_count_o <= mismatches;
      pending_o    <= lock_expect.size();
    end
  end

endmodule

>>> tb/password_door_lock_controller_top_test.sv
// Testbench top of the keypad door lock: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module password_door_lock_controller_top_test;
  import pdl_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 210;

  typedef logic [KEY_W-1:0] code_t [$];

  logic clk_i;
  logic rst_ni;

  pdl_in_if  in_if ();
  pdl_out_if out_if ();
  pdl_cfg_if cfg_if ();

  int fail_count;
  int words_pending;
  int words_sent = 0;
  int idle_cycles = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int out_stall = 0;

  // What the stimulus knows of the lock, enough to pick the next sequence
  code_t pw;
  bit    at_menu = 1'b0;
  int    misses = 0;
  int    tps_eff = 31;
  int    unlock_s = 15;
  int    hold_s = 3;
  int    alarm_s = 60;
  int    wrong_lim = 3;

  password_door_lock_controller_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  password_door_lock_controller_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stall the result side for a random number of cycles after each word
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 6);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_if.ready <= (out_stall == 0);
    end
  end

  // End the run when no channel moves a word for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("password_door_lock_controller_top_test failed");
      $finish;
    end
  end

  task automatic send_word(req_e req, logic [KEY_W-1:0] key);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= req;
    in_if.key_byte <= key;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  task automatic send_entry(code_t c);
    foreach (c[i]) send_word(REQ_KEY, c[i]);
    send_word(REQ_KEY, KEY_END);
  endtask

  // Drop valid and hold until every expected result word has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  function automatic logic [KEY_W-1:0] any_key_but_end();
    logic [KEY_W-1:0] k;
    do k = KEY_W'($urandom_range(0, 255)); while (k == KEY_END);
    return k;
  endfunction

  function automatic code_t make_code(int len);
    code_t c;
    repeat (len) c.push_back(any_key_but_end());
    return c;
  endfunction

  // Mostly short passwords, now and then empty or too long
  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, PASS_MAX + 2) : $urandom_range(1, 6);
  endfunction

  function automatic bit same_code(code_t a, code_t b);
    if (a.size() != b.size()) return 1'b0;
    foreach (a[i]) if (a[i] != b[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Corrupt an entry: flip a key, drop or add one, empty it, or make it too long
  function automatic code_t garble(code_t c);
    code_t w;
    int pos;
    logic [KEY_W-1:0] flip;
    w = c;
    case ($urandom_range(0, 4))
      0: begin
        if (w.size() != 0) begin
          pos = $urandom_range(0, w.size() - 1);
          do flip = KEY_W'($urandom_range(1, 255)); while ((w[pos] ^ flip) == KEY_END);
          w[pos] = w[pos] ^ flip;
        end else begin
          w.push_back(any_key_but_end());
        end
      end
      1: if (w.size() != 0) void'(w.pop_back());
      2: w.push_back(any_key_but_end());
      3: w.delete();
      default: w = make_code(PASS_MAX + 1 + $urandom_range(0, 1));
    endcase
    return w;
  endfunction

  function automatic int span_ticks(int secs);
    return (secs == 0) ? 1 : secs * tps_eff;
  endfunction

  // Feed the ticks of a timed span, with stray keys that the lock ignores
  task automatic run_span(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(REQ_KEY, KEY_W'($urandom_range(0, 255)));
      send_word(REQ_TICK, KEY_W'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 2)) send_word(REQ_TICK, KEY_W'($urandom_range(0, 255)));
  endtask

  // Set a password, or pick an option from the menu and try the password
  task automatic run_session();
    code_t entry;
    code_t retype;
    code_t guess;
    bit open_it;
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 7) == 0) send_word(REQ_TICK, KEY_W'($urandom_range(0, 255)));
    if (!at_menu) begin
      entry  = make_code(pick_len());
      retype = ($urandom_range(0, 3) != 0) ? entry : garble(entry);
      send_entry(entry);
      send_entry(retype);
      at_menu = same_code(entry, retype) && entry.size() >= 1 && entry.size() <= PASS_MAX;
      if (at_menu) pw = entry;
    end else begin
      open_it = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(0, 2)) begin
        do k = KEY_W'($urandom_range(0, 255)); while (k == KEY_OPEN || k == KEY_CHANGE);
        send_word(REQ_KEY, k);
      end
      send_word(REQ_KEY, open_it ? KEY_OPEN : KEY_CHANGE);
      forever begin
        guess = ($urandom_range(0, 9) < 6) ? pw : garble(pw);
        send_entry(guess);
        if (same_code(guess, pw)) begin
          misses = 0;
          if (open_it) begin
            run_span(span_ticks(unlock_s) + ((hold_s != 0) ? hold_s * tps_eff : 0) +
                     span_ticks(unlock_s));
          end else begin
            at_menu = 1'b0;
          end
          break;
        end
        misses++;
        if (misses >= wrong_lim) begin
          misses = 0;
          run_span(span_ticks(alarm_s));
          break;
        end
      end
    end
  endtask

  // Reprogram all registers while idle, then run random sessions
  task automatic run_phase(logic [CFG_DAT_W-1:0] tps, logic [CFG_DAT_W-1:0] unl,
                           logic [CFG_DAT_W-1:0] hold, logic [CFG_DAT_W-1:0] alarm,
                           logic [CFG_DAT_W-1:0] maxw);
    int phase_end;
    drain();
    write_reg(CFG_TPS, tps);
    write_reg(CFG_UNLOCK, unl);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_ALARM, alarm);
    write_reg(CFG_MAXW, maxw);
    cfg_if.valid <= 1'b0;
    tps_eff   = (tps == 0) ? 1 : int'(tps);
    unlock_s  = int'(unl);
    hold_s    = int'(hold);
    alarm_s   = int'(alarm);
    wrong_lim = (maxw[WRONG_W-1:0] == 0) ? 1 : int'(maxw[WRONG_W-1:0]);
    phase_end = words_sent + PHASE_WORDS;
    while (words_sent < phase_end) run_session();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.req_type  = REQ_KEY;
    in_if.key_byte  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_TPS;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stray tick, confirm of wrong length, empty password
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_KEY, 8'h00);
    send_word(REQ_KEY, 8'hFF);
    send_word(REQ_KEY, KEY_END);
    send_word(REQ_KEY, 8'h00);
    send_word(REQ_KEY, KEY_END);
    send_word(REQ_KEY, KEY_END);
    send_word(REQ_KEY, KEY_END);
    // Directed: good password into the menu, menu key, wrong try, change by match
    send_word(REQ_KEY, 8'hAA);
    send_word(REQ_KEY, 8'h55);
    send_word(REQ_KEY, KEY_END);
    send_word(REQ_KEY, 8'hAA);
    send_word(REQ_KEY, 8'h55);
    send_word(REQ_KEY, KEY_END);
    send_word(REQ_KEY, 8'h10);
    send_word(REQ_TICK, 8'hFF);
    send_word(REQ_KEY, KEY_CHANGE);
    send_word(REQ_KEY, 8'hAA);
    send_word(REQ_KEY, KEY_END);
    send_word(REQ_KEY, 8'hAA);
    send_word(REQ_KEY, 8'h55);
    send_word(REQ_KEY, KEY_END);

    // Random sessions over a range of settings, extremes first
    run_phase(6'd1, 6'd2, 6'd0, 6'd1, 6'd1);
    run_phase(6'd63, 6'd1, 6'd1, 6'd1, 6'd2);
    run_phase(6'd0, 6'd0, 6'd0, 6'd0, 6'h3C);
    run_phase(6'd1, 6'd63, 6'd63, 6'd63, 6'h3F);
    repeat (4) begin
      run_phase(CFG_DAT_W'($urandom_range(0, 3)), CFG_DAT_W'($urandom_range(0, 3)),
                CFG_DAT_W'($urandom_range(0, 3)), CFG_DAT_W'($urandom_range(0, 3)),
                CFG_DAT_W'($urandom_range(0, 63)));
    end

    drain();
    if (fail_count == 0 && words_pending == 0) begin
      $display("password_door_lock_controller_top_test passed");
    end else begin
      $display("password_door_lock_controller_top_test failed");
    end
    $finish;
  end

endmodule
